@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Same-cycle and next-cycle implication checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/lpd_pkg.sv @@
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared constants and register codes of the 3x3 local peak detector.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

  localparam int PIX_W        = 16;
  localparam int FRAME_W      = 16;
  localparam int CFG_THR_W    = 16;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_MARGIN_W = 3;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [CFG_THR_W-1:0]    RST_THRESHOLD = 16'd0;
  localparam logic [CFG_WIDTH_W-1:0]  RST_WIDTH     = 11'd1024;
  localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT    = 13'd1024;
  localparam logic [CFG_MARGIN_W-1:0] RST_MARGIN    = 3'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2,
    REG_MARGIN    = 2'd3
  } cfg_reg_e;

endpackage

`default_nettype wire

@@ rtl/lpd_ram.sv @@
// ----------------------------------------------------------------------------
// lpd_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/local_peak_detector_3x3.sv @@
// Pipeline: an accepted pixel moves through the stage B, stage C and output
//   registers before its peak word shows on m_tvalid_o.
// Throughput: one pixel per cycle while no held result stalls the pipe; the single
//   line memory is read once and written once per pixel, so it never limits the rate.
// Back-pressure: a held result stalls the whole pipe; otherwise it flows.
// Reset: rst_ni clears counters, window and pipe valids and loads the config registers with their reset values;
// ----------------------------------------------------------------------------
// local_peak_detector_3x3
// 3x3 non-maximum suppression over a raster pixel stream, emitting the
// coordinates and frame index of each local peak. The line memory has no
// clearing pass; an entry is valid once a row has written it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module local_peak_detector_3x3 #(
  parameter int MAX_WIDTH  = lpd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lpd_pkg::DEF_MAX_HEIGHT,
  localparam int XW        = $clog2(MAX_WIDTH),
  localparam int YW        = $clog2(MAX_HEIGHT),
  localparam int OUT_W     = ((XW + YW + lpd_pkg::FRAME_W + 7) / 8) * 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // pixel input
  input  wire logic                              s_tvalid_i,
  output logic                                   s_tready_o,
  input  wire logic [lpd_pkg::PIX_W-1:0]         s_tdata_i,  // [15:0] pixel_value
  input  wire logic                              s_tuser_i,  // [0] start_of_frame
  // peak output
  output logic                                   m_tvalid_o,
  input  wire logic                              m_tready_i,
  output logic      [OUT_W-1:0]                  m_tdata_o,  // peak_x, peak_y, frame_number
  // configuration writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lpd_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [lpd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int PW   = lpd_pkg::PIX_W;
  localparam int FW   = lpd_pkg::FRAME_W;
  localparam int WCW  = (XW + 1 > lpd_pkg::CFG_WIDTH_W)  ? XW + 1 : lpd_pkg::CFG_WIDTH_W;
  localparam int HCW  = (YW + 1 > lpd_pkg::CFG_HEIGHT_W) ? YW + 1 : lpd_pkg::CFG_HEIGHT_W;
  localparam int MW   = lpd_pkg::CFG_MARGIN_W;
  localparam int PADW = OUT_W - (XW + YW + FW);

  // --------------------------------------------------------------------------
  // Configuration registers: always ready, one register per write word.
  // --------------------------------------------------------------------------
  logic [lpd_pkg::CFG_THR_W-1:0]    cfg_thr_q;
  logic [lpd_pkg::CFG_WIDTH_W-1:0]  cfg_width_q;
  logic [lpd_pkg::CFG_HEIGHT_W-1:0] cfg_height_q;
  logic [MW-1:0]                    cfg_margin_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_thr_q    <= lpd_pkg::RST_THRESHOLD;
      cfg_width_q  <= lpd_pkg::RST_WIDTH;
      cfg_height_q <= lpd_pkg::RST_HEIGHT;
      cfg_margin_q <= lpd_pkg::RST_MARGIN;
    end else if (cfg_valid_i) begin
      case (lpd_pkg::cfg_reg_e'(cfg_index_i))
        lpd_pkg::REG_THRESHOLD: cfg_thr_q    <= cfg_data_i[lpd_pkg::CFG_THR_W-1:0];
        lpd_pkg::REG_WIDTH:     cfg_width_q  <= cfg_data_i[lpd_pkg::CFG_WIDTH_W-1:0];
        lpd_pkg::REG_HEIGHT:    cfg_height_q <= cfg_data_i[lpd_pkg::CFG_HEIGHT_W-1:0];
        lpd_pkg::REG_MARGIN:    cfg_margin_q <= cfg_data_i[MW-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero or oversize saturates to the maximum; a zero margin counts as one.
  logic [WCW-1:0] w_ext, eff_w;
  logic [HCW-1:0] h_ext, eff_h;
  logic [MW-1:0]  marg;

  always_comb begin
    w_ext = WCW'(cfg_width_q);
    h_ext = HCW'(cfg_height_q);
    eff_w = (w_ext == '0 || w_ext > WCW'(MAX_WIDTH))  ? WCW'(MAX_WIDTH)  : w_ext;
    eff_h = (h_ext == '0 || h_ext > HCW'(MAX_HEIGHT)) ? HCW'(MAX_HEIGHT) : h_ext;
    marg  = (cfg_margin_q == '0) ? MW'(1) : cfg_margin_q;
  end

  // --------------------------------------------------------------------------
  // Pipe control. Everything advances together unless a result is held.
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic adv;
  logic accept;

  assign adv        = !out_valid_q || m_tready_i;
  assign s_tready_o = adv;
  assign accept     = s_tvalid_i && adv;

  // --------------------------------------------------------------------------
  // Stage A (accept cycle): position counters, candidate test, memory read.
  // --------------------------------------------------------------------------
  logic [XW-1:0] col_q;
  logic [YW-1:0] row_q;
  logic [FW-1:0] frame_q;

  logic [XW-1:0]  c_a, cx_a;
  logic [YW-1:0]  r_a, cy_a;
  logic [FW-1:0]  frame_a;
  logic [WCW-1:0] col_inc, cx_ext;
  logic [HCW-1:0] row_inc, cy_ext;
  logic           row_wrap, frame_end, cand_a;

  always_comb begin
    c_a       = s_tuser_i ? '0 : col_q;
    r_a       = s_tuser_i ? '0 : row_q;
    // a start marker away from the origin closes the cut-short frame
    frame_a   = frame_q + FW'(s_tuser_i && (col_q != '0 || row_q != '0));
    col_inc   = WCW'(c_a) + WCW'(1);
    row_inc   = HCW'(r_a) + HCW'(1);
    row_wrap  = col_inc >= eff_w;
    frame_end = row_inc >= eff_h;
    // the window completed by pixel (c, r) is centered on (c-1, r-1)
    cx_a      = c_a - XW'(1);
    cy_a      = r_a - YW'(1);
    cx_ext    = WCW'(cx_a);
    cy_ext    = HCW'(cy_a);
    cand_a    = (c_a != '0) && (r_a != '0)
             && (cx_ext >= WCW'(marg)) && (cx_ext + WCW'(marg) < eff_w)
             && (cy_ext >= HCW'(marg)) && (cy_ext + HCW'(marg) < eff_h);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      frame_q <= '0;
    end else if (accept) begin
      if (row_wrap) begin
        col_q <= '0;
        if (frame_end) begin
          row_q   <= '0;
          frame_q <= frame_a + FW'(1);
        end else begin
          row_q   <= row_inc[YW-1:0];
          frame_q <= frame_a;
        end
      end else begin
        col_q   <= col_inc[XW-1:0];
        row_q   <= r_a;
        frame_q <= frame_a;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line memory: one word per column, {upper row, middle row}.
  // --------------------------------------------------------------------------
  logic [2*PW-1:0] ram_rdata;
  logic [2*PW-1:0] wr_word;
  logic [2*PW-1:0] wr_word_q;
  logic            ram_we;

  // Stage B registers
  logic          b_valid_q, b_fwd_q, b_cand_q;
  logic [XW-1:0] b_idx_q, b_cx_q;
  logic [YW-1:0] b_cy_q;
  logic [PW-1:0] b_pix_q;
  logic [FW-1:0] b_frame_q;

  lpd_ram #(
    .WIDTH(2 * PW),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(b_idx_q),
    .wdata_i(wr_word),
    .re_i   (accept),
    .raddr_i(c_a),
    .rdata_o(ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage B: read data returns; forward if the previous pixel wrote the same
  // column in the cycle this one was read; shift the rows down and write back.
  // --------------------------------------------------------------------------
  logic [2*PW-1:0] rd_eff;
  logic [PW-1:0]   up_b, mid_b;

  always_comb begin
    rd_eff  = b_fwd_q ? wr_word_q : ram_rdata;
    up_b    = rd_eff[2*PW-1:PW];
    mid_b   = rd_eff[PW-1:0];
    wr_word = {mid_b, b_pix_q};
    ram_we  = adv && b_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_fwd_q   <= 1'b0;
    end else if (adv) begin
      b_valid_q <= accept;
      b_fwd_q   <= accept && b_valid_q && (b_idx_q == c_a);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_idx_q   <= c_a;
      b_pix_q   <= s_tdata_i;
      b_cand_q  <= cand_a;
      b_cx_q    <= cx_a;
      b_cy_q    <= cy_a;
      b_frame_q <= frame_a;
    end
    if (ram_we) begin
      wr_word_q <= wr_word;
    end
  end

  // 3x3 window, index row*3+col, row 0 on top, col 2 newest
  logic [PW-1:0] win_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (ram_we) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= up_b;
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[5] <= mid_b;
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[8] <= b_pix_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: compare the center against threshold and neighbors.
  // --------------------------------------------------------------------------
  logic          c_valid_q, c_cand_q;
  logic [XW-1:0] c_cx_q;
  logic [YW-1:0] c_cy_q;
  logic [FW-1:0] c_frame_q;
  logic          is_peak;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (adv) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      c_cand_q  <= b_cand_q;
      c_cx_q    <= b_cx_q;
      c_cy_q    <= b_cy_q;
      c_frame_q <= b_frame_q;
    end
  end

  always_comb begin
    // plateau tie-break: a center equal to its upper or left neighbor loses
    is_peak = (win_q[4] >= cfg_thr_q) && (win_q[4] != win_q[1]) && (win_q[4] != win_q[3]);
    for (int i = 0; i < 9; i++) begin
      if (win_q[4] < win_q[i]) begin
        is_peak = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: hold the peak word until taken.
  // --------------------------------------------------------------------------
  logic [XW-1:0] out_x_q;
  logic [YW-1:0] out_y_q;
  logic [FW-1:0] out_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= c_valid_q && c_cand_q && is_peak;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_x_q     <= c_cx_q;
      out_y_q     <= c_cy_q;
      out_frame_q <= c_frame_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  generate
    if (PADW > 0) begin : g_pad
      assign m_tdata_o = {PADW'(0), out_frame_q, out_y_q, out_x_q};
    end else begin : g_nopad
      assign m_tdata_o = {out_frame_q, out_y_q, out_x_q};
    end
  endgenerate

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // forwarding only ever applies to a live pixel in stage B
  `ASSERT_SAME(a_fwd_live, clk_i, rst_ni, b_fwd_q, b_valid_q)
  // a same-column read during a write-back must pick up the forwarded word
  `ASSERT_NEXT(a_fwd_taken, clk_i, rst_ni, accept && b_valid_q && (b_idx_q == c_a), b_fwd_q)
  // a held result freezes the window
  `ASSERT_NEXT(a_win_hold, clk_i, rst_ni, !adv, $stable(win_q[4]) && $stable(win_q[8]))
  // the border margin is at least one, so no peak sits on row or column zero
  `ASSERT_SAME(a_peak_inside, clk_i, rst_ni, out_valid_q, (out_x_q != '0) && (out_y_q != '0))

endmodule

`default_nettype wire
